// File: rtl/core/tgarle_pkg.sv
// Shared types and constants for the TGA RLE pixel decoder.
// Used by every module in rtl/core; no dependencies of its own.

package tgarle_pkg;

    localparam int QueueDepth = 4;

    localparam logic [4:0] HeaderBytes = 5'd18;
    localparam logic [4:0] PosIdLen    = 5'd0;
    localparam logic [4:0] PosMapType  = 5'd1;
    localparam logic [4:0] PosType     = 5'd2;
    localparam logic [4:0] PosWidthLo  = 5'd12;
    localparam logic [4:0] PosWidthHi  = 5'd13;
    localparam logic [4:0] PosHeightLo = 5'd14;
    localparam logic [4:0] PosHeightHi = 5'd15;
    localparam logic [4:0] PosDepth    = 5'd16;
    localparam logic [4:0] PosLast     = 5'd17;

    localparam logic [7:0] TypeRaw = 8'd2;
    localparam logic [7:0] TypeRle = 8'd10;
    localparam logic [7:0] Depth24 = 8'd24;
    localparam logic [7:0] Depth32 = 8'd32;

    localparam logic [1:0] StatusOk       = 2'd0;
    localparam logic [1:0] StatusBadType  = 2'd1;
    localparam logic [1:0] StatusBadDepth = 2'd2;

    typedef struct packed {
        logic [31:0] pixel;
        logic        four_byte;
        logic [7:0]  repeat_count;
        logic        last_pixel;
        logic [1:0]  status;
    } result_rec_t;

endpackage

// File: rtl/core/tgarle_parser.sv
// Front end: accepts file bytes, parses the TGA header and the packets, and
// produces one result record per finished pixel or header error. Uses tgarle_pkg.

module tgarle_parser (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              in_byte,
    input  logic                    in_sof,
    input  logic                    queue_full,
    output logic                    push,
    output tgarle_pkg::result_rec_t push_rec
);
    import tgarle_pkg::*;

    logic [4:0]  hp_reg, hp_next;
    logic        rle_reg, rle_next;
    logic        four_reg, four_next;
    logic [15:0] w_reg, w_next;
    logic [15:0] h_reg, h_next;
    logic [31:0] pl_reg, pl_next;
    logic        run_reg, run_next;
    logic [7:0]  ppl_reg, ppl_next;
    logic [1:0]  bip_reg, bip_next;
    logic [31:0] asm_reg, asm_next;
    logic        stop_reg, stop_next;

    logic        accept;
    logic [4:0]  hp_eff;
    logic        stop_eff;
    logic [8:0]  pkt_count;
    logic [7:0]  rep_raw;
    logic [7:0]  rep;
    logic [31:0] pl_after;
    logic        pixel_done;

    assign in_ready = !queue_full;
    assign accept   = in_valid && !queue_full;
    assign hp_eff   = in_sof ? '0 : hp_reg;
    assign stop_eff = in_sof ? 1'b0 : stop_reg;

    assign pkt_count  = {2'b00, in_byte[6:0]} + 9'd1;
    assign pixel_done = (bip_reg == (four_reg ? 2'd3 : 2'd2));
    assign rep_raw    = (rle_reg && run_reg) ? ppl_reg : 8'd1;
    assign rep        = (pl_reg < {24'd0, rep_raw}) ? pl_reg[7:0] : rep_raw;
    assign pl_after   = pl_reg - {24'd0, rep};

    always_comb
    begin
        hp_next   = hp_reg;
        rle_next  = rle_reg;
        four_next = four_reg;
        w_next    = w_reg;
        h_next    = h_reg;
        pl_next   = pl_reg;
        run_next  = run_reg;
        ppl_next  = ppl_reg;
        bip_next  = bip_reg;
        asm_next  = asm_reg;
        stop_next = stop_reg;
        push      = 1'b0;
        push_rec  = '0;
        if (accept)
        begin
            if (in_sof)
            begin
                hp_next   = '0;
                stop_next = 1'b0;
                run_next  = 1'b0;
                ppl_next  = '0;
                bip_next  = '0;
                asm_next  = '0;
                pl_next   = '0;
                w_next    = '0;
                h_next    = '0;
            end
            if (!stop_eff)
            begin
                if (hp_eff < HeaderBytes)
                begin
                    hp_next = hp_eff + 5'd1;
                    unique case (hp_eff) inside
                        PosIdLen, PosMapType:
                        begin
                            if (in_byte != 8'd0)
                            begin
                                stop_next       = 1'b1;
                                push            = 1'b1;
                                push_rec.status = StatusBadType;
                            end
                        end
                        PosType:
                        begin
                            if (in_byte == TypeRaw)
                                rle_next = 1'b0;
                            else if (in_byte == TypeRle)
                                rle_next = 1'b1;
                            else
                            begin
                                stop_next       = 1'b1;
                                push            = 1'b1;
                                push_rec.status = StatusBadType;
                            end
                        end
                        PosWidthLo:  w_next = {w_reg[15:8], in_byte};
                        PosWidthHi:  w_next = {in_byte, w_reg[7:0]};
                        PosHeightLo: h_next = {h_reg[15:8], in_byte};
                        PosHeightHi: h_next = {in_byte, h_reg[7:0]};
                        PosDepth:
                        begin
                            if (in_byte == Depth24)
                                four_next = 1'b0;
                            else if (in_byte == Depth32)
                                four_next = 1'b1;
                            else
                            begin
                                stop_next       = 1'b1;
                                push            = 1'b1;
                                push_rec.status = StatusBadDepth;
                            end
                        end
                        PosLast:
                        begin
                            pl_next = {16'd0, w_reg} * {16'd0, h_reg};
                            if (w_reg == 16'd0 || h_reg == 16'd0)
                                stop_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
                else if (rle_reg && ppl_reg == 8'd0)
                begin
                    run_next = in_byte[7];
                    ppl_next = (pl_reg < {23'd0, pkt_count}) ? pl_reg[7:0] : pkt_count[7:0];
                    bip_next = '0;
                end
                else
                begin
                    asm_next[{bip_reg, 3'b000} +: 8] = in_byte;
                    if (!pixel_done)
                        bip_next = bip_reg + 2'd1;
                    else
                    begin
                        bip_next = '0;
                        if (rle_reg && run_reg)
                            ppl_next = '0;
                        else if (rle_reg)
                            ppl_next = ppl_reg - 8'd1;
                        pl_next = pl_after;
                        if (pl_after == 32'd0)
                            stop_next = 1'b1;
                        push                  = 1'b1;
                        push_rec.pixel        = asm_next;
                        push_rec.four_byte    = four_reg;
                        push_rec.repeat_count = rep;
                        push_rec.last_pixel   = (pl_after == 32'd0);
                        push_rec.status       = StatusOk;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_reg   <= '0;
            rle_reg  <= 1'b0;
            four_reg <= 1'b0;
            w_reg    <= '0;
            h_reg    <= '0;
            pl_reg   <= '0;
            run_reg  <= 1'b0;
            ppl_reg  <= '0;
            bip_reg  <= '0;
            asm_reg  <= '0;
            stop_reg <= 1'b1;
        end
        else
        begin
            hp_reg   <= hp_next;
            rle_reg  <= rle_next;
            four_reg <= four_next;
            w_reg    <= w_next;
            h_reg    <= h_next;
            pl_reg   <= pl_next;
            run_reg  <= run_next;
            ppl_reg  <= ppl_next;
            bip_reg  <= bip_next;
            asm_reg  <= asm_next;
            stop_reg <= stop_next;
        end
    end

endmodule

// File: rtl/core/tgarle_queue.sv
// Short result queue between the parser and the output stage.
// Uses tgarle_pkg for the record type.

module tgarle_queue #(
    parameter int DEPTH = tgarle_pkg::QueueDepth
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  tgarle_pkg::result_rec_t push_rec,
    input  logic                    pop,
    output logic                    head_valid,
    output tgarle_pkg::result_rec_t head_rec,
    output logic                    full
);
    import tgarle_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    result_rec_t     mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_pop;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CntW'(DEPTH));
    assign head_rec   = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        if (push && !do_pop)
            count_next = count_reg + CntW'(1);
        else if (!push && do_pop)
            count_next = count_reg - CntW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/tgarle_out.sv
// Back end: turns a queued BGR(A) record into an RGBA output word and holds it
// in the output register until the receiver takes it. Uses tgarle_pkg.

module tgarle_out (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    head_valid,
    input  tgarle_pkg::result_rec_t head_rec,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [39:0]             out_data,
    output logic                    out_last,
    output logic [1:0]              out_user
);
    import tgarle_pkg::*;

    logic        valid_reg;
    logic [39:0] data_reg, data_next;
    logic        last_reg;
    logic [1:0]  user_reg;
    logic [7:0]  alpha;

    assign pop       = head_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;
    assign out_user  = user_reg;

    always_comb
    begin
        alpha = head_rec.four_byte ? head_rec.pixel[31:24] : 8'hFF;
        if (head_rec.status != StatusOk)
            data_next = '0;
        else
            data_next = {head_rec.repeat_count, alpha, head_rec.pixel[7:0],
                         head_rec.pixel[15:8], head_rec.pixel[23:16]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= data_next;
            last_reg <= head_rec.last_pixel;
            user_reg <= head_rec.status;
        end
    end

endmodule

// File: rtl/core/tga_rle_pixel_decoder.sv
// Top level of the TGA truecolor (24/32 bpp, raw or RLE) pixel decoder.
// Instantiates tgarle_parser, tgarle_queue and tgarle_out; uses tgarle_pkg.
//
// Usage: the input stream carries one file byte per word in s_axis_tdata, with
// s_axis_tuser high on the first header byte, which restarts the parser at any
// time. The output stream carries one word per decoded pixel or run, or one
// word with a nonzero status in m_axis_tuser when the header is unsupported;
// m_axis_tlast marks the word that completes the image. Header bytes, packet
// header bytes and the first bytes of a pixel give no output word.
// Throughput is one input byte per cycle while the queue has room. The parser
// handles each byte in the cycle it is accepted and places any result in a
// four-entry queue; the output register loads it from there when empty or
// being read and then drives m_axis_tvalid. When the receiver stalls the
// queue fills, and s_axis_tready drops only once all four entries are
// occupied. After reset the parser waits for a start byte and ignores all
// other bytes; it stops again after an error, empty image or last pixel.

module tga_rle_pixel_decoder #(
    parameter int QUEUE_DEPTH = tgarle_pkg::QueueDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic        s_axis_tuser,   // start_of_file
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // red, green, blue, alpha, repeat_count
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser    // status
);
    import tgarle_pkg::*;

    logic        push;
    result_rec_t push_rec;
    logic        pop;
    logic        head_valid;
    result_rec_t head_rec;
    logic        queue_full;

    tgarle_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_sof     (s_axis_tuser),
        .queue_full (queue_full),
        .push       (push),
        .push_rec   (push_rec)
    );

    tgarle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .full       (queue_full)
    );

    tgarle_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_last   (m_axis_tlast),
        .out_user   (m_axis_tuser)
    );

endmodule

// File: dv/tb_tga_rle_pixel_decoder.sv
// Self-checking testbench for tga_rle_pixel_decoder: directed and random TGA byte streams,
// predicted word by word and compared on the output stream with random idling on both sides.
// Depends on rtl/core/tgarle_pkg.sv and the decoder RTL under rtl/core.

module tb_tga_rle_pixel_decoder;
    import tgarle_pkg::*;

    localparam int CycleLimit = 1000000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] count;
        logic       last;
        logic [1:0] status;
    } pixel_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    // Decoder image of the block.
    logic [4:0]  hdr_pos = 5'd0;
    logic        rle_file = 1'b0;
    logic        wide_pixels = 1'b0;
    logic [15:0] img_w = 16'd0;
    logic [15:0] img_h = 16'd0;
    logic [31:0] pixels_todo = 32'd0;
    logic        in_run = 1'b0;
    logic [7:0]  packet_todo = 8'd0;
    logic [1:0]  byte_idx = 2'd0;
    logic [31:0] color_acc = 32'd0;
    logic        halted = 1'b1;

    pixel_word_t pending_words[$];
    int          mismatches = 0;
    int          words_checked = 0;
    int          decoded_bytes = 0;
    int          sent_bytes = 0;
    int          files_started = 0;
    int          cycles = 0;
    bit          sender_burst = 1'b0;

    tga_rle_pixel_decoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 2);
        else if (r < 96)
            return $urandom_range(3, 8);
        else
            return $urandom_range(12, 40);
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic sof, output bit active);
        pixel_word_t w;
        logic [4:0]  pos;
        logic [31:0] n;
        logic        err;
        begin
            w = '0;
            err = 1'b0;
            active = 1'b0;
            if (sof)
            begin
                hdr_pos = 5'd0;
                halted = 1'b0;
                in_run = 1'b0;
                packet_todo = 8'd0;
                byte_idx = 2'd0;
                color_acc = 32'd0;
                pixels_todo = 32'd0;
                img_w = 16'd0;
                img_h = 16'd0;
            end
            if (!halted)
            begin
                active = 1'b1;
                if (hdr_pos < HeaderBytes)
                begin
                    pos = hdr_pos;
                    hdr_pos = hdr_pos + 5'd1;
                    case (pos)
                        PosIdLen, PosMapType:
                            if (b != 8'd0)
                            begin
                                err = 1'b1;
                                w.status = StatusBadType;
                            end
                        PosType:
                            if (b == TypeRaw)
                                rle_file = 1'b0;
                            else if (b == TypeRle)
                                rle_file = 1'b1;
                            else
                            begin
                                err = 1'b1;
                                w.status = StatusBadType;
                            end
                        PosWidthLo:  img_w[7:0] = b;
                        PosWidthHi:  img_w[15:8] = b;
                        PosHeightLo: img_h[7:0] = b;
                        PosHeightHi: img_h[15:8] = b;
                        PosDepth:
                            if (b == Depth24)
                                wide_pixels = 1'b0;
                            else if (b == Depth32)
                                wide_pixels = 1'b1;
                            else
                            begin
                                err = 1'b1;
                                w.status = StatusBadDepth;
                            end
                        PosLast:
                        begin
                            pixels_todo = {16'd0, img_w} * {16'd0, img_h};
                            if (pixels_todo == 32'd0)
                                halted = 1'b1;
                        end
                        default: ;
                    endcase
                    if (err)
                    begin
                        halted = 1'b1;
                        pending_words.push_back(w);
                    end
                end
                else if (rle_file && packet_todo == 8'd0)
                begin
                    n = {25'd0, b[6:0]} + 32'd1;
                    in_run = b[7];
                    if (n > pixels_todo)
                        n = pixels_todo;
                    packet_todo = n[7:0];
                    byte_idx = 2'd0;
                end
                else
                begin
                    if (byte_idx == 2'd0)
                        color_acc = 32'd0;
                    color_acc = color_acc | ({24'd0, b} << (8 * byte_idx));
                    byte_idx = byte_idx + 2'd1;
                    if (byte_idx == 2'd0 || (!wide_pixels && byte_idx == 2'd3))
                    begin
                        byte_idx = 2'd0;
                        if (rle_file && in_run)
                        begin
                            n = {24'd0, packet_todo};
                            packet_todo = 8'd0;
                        end
                        else
                        begin
                            n = 32'd1;
                            if (rle_file)
                                packet_todo = packet_todo - 8'd1;
                        end
                        if (n > pixels_todo)
                            n = pixels_todo;
                        pixels_todo = pixels_todo - n;
                        w.last = (pixels_todo == 32'd0);
                        if (w.last)
                            halted = 1'b1;
                        w.red = color_acc[23:16];
                        w.green = color_acc[15:8];
                        w.blue = color_acc[7:0];
                        w.alpha = wide_pixels ? color_acc[31:24] : 8'hFF;
                        w.count = n[7:0];
                        w.status = StatusOk;
                        pending_words.push_back(w);
                    end
                end
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic sof);
        int  gap;
        bit  active;
        begin
            gap = sender_burst ? 0 : idle_len();
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= b;
            s_axis_tuser <= sof;
            do
                @(posedge clk);
            while (!s_axis_tready);
            decode_byte(b, sof, active);
            sent_bytes++;
            if (active)
                decoded_bytes++;
            if (sof)
                files_started++;
        end
    endtask

    task automatic send_header(input logic [7:0] id_len, input logic [7:0] map_type,
                               input logic [7:0] img_type, input logic [15:0] w,
                               input logic [15:0] h, input logic [7:0] depth);
        logic [7:0] hb;
        begin
            for (int i = 0; i < 18; i++)
            begin
                case (i)
                    0:  hb = id_len;
                    1:  hb = map_type;
                    2:  hb = img_type;
                    12: hb = w[7:0];
                    13: hb = w[15:8];
                    14: hb = h[7:0];
                    15: hb = h[15:8];
                    16: hb = depth;
                    default: hb = 8'($urandom);
                endcase
                send_byte(hb, i == 0);
            end
        end
    endtask

    task automatic send_pixel(input logic wide, input logic [31:0] color);
        send_byte(color[7:0], 1'b0);
        send_byte(color[15:8], 1'b0);
        send_byte(color[23:16], 1'b0);
        if (wide)
            send_byte(color[31:24], 1'b0);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_bytes_before_start();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h0A, 1'b0);
    endtask

    task automatic test_bad_headers();
        send_header(8'hFF, 8'h00, TypeRaw, 16'd1, 16'd1, Depth24);
        send_header(8'h00, 8'h01, TypeRle, 16'd1, 16'd1, Depth32);
        send_header(8'h00, 8'h00, 8'h03, 16'd2, 16'd2, Depth24);
        send_header(8'h00, 8'h00, 8'hFF, 16'd2, 16'd2, Depth24);
        send_header(8'h00, 8'h00, TypeRaw, 16'd1, 16'd1, 8'd16);
        send_header(8'h00, 8'h00, TypeRle, 16'd1, 16'd1, 8'hFF);
        send_byte(8'h5A, 1'b0);
    endtask

    task automatic test_empty_image();
        send_header(8'h00, 8'h00, TypeRaw, 16'd0, 16'd5, Depth24);
        send_byte(8'hC3, 1'b0);
        send_header(8'h00, 8'h00, TypeRle, 16'd7, 16'd0, Depth32);
        send_byte(8'h81, 1'b0);
    endtask

    task automatic test_raw_pixels();
        send_header(8'h00, 8'h00, TypeRaw, 16'd2, 16'd1, Depth24);
        send_pixel(1'b0, 32'h0000_0000);
        send_pixel(1'b0, 32'h00FF_FFFF);
        send_byte(8'h11, 1'b0);
        send_header(8'h00, 8'h00, TypeRaw, 16'd1, 16'd2, Depth32);
        send_pixel(1'b1, 32'hFF00_0000);
        send_pixel(1'b1, 32'h00A5_5AFF);
    endtask

    task automatic test_rle_packets();
        send_header(8'h00, 8'h00, TypeRle, 16'd130, 16'd1, Depth32);
        send_byte(8'hFF, 1'b0);
        send_pixel(1'b1, $urandom);
        send_byte(8'h01, 1'b0);
        send_pixel(1'b1, $urandom);
        send_pixel(1'b1, $urandom);
        // A raw packet of 128 on a three-pixel image is clipped.
        send_header(8'h00, 8'h00, TypeRle, 16'd3, 16'd1, Depth24);
        send_byte(8'h7F, 1'b0);
        repeat (3) send_pixel(1'b0, $urandom);
        send_header(8'h00, 8'h00, TypeRle, 16'd2, 16'd2, Depth24);
        send_byte(8'hFF, 1'b0);
        send_pixel(1'b0, $urandom);
    endtask

    task automatic test_restart();
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(TypeRle, 1'b0);
        send_header(8'h00, 8'h00, TypeRle, 16'hFFFF, 16'hFFFF, Depth32);
        send_byte(8'h05, 1'b0);
        send_pixel(1'b1, $urandom);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_header(8'h00, 8'h00, TypeRle, 16'd1, 16'd1, Depth24);
        send_byte(8'h80, 1'b0);
        send_pixel(1'b0, $urandom);
        wait_drained();
    endtask

    task automatic test_random_files();
        int         r;
        int         w;
        int         h;
        int         total;
        int         sent;
        int         stop_at;
        int         n;
        int         count;
        logic [7:0] img_type;
        logic [7:0] depth;
        logic       wide;
        logic       run;
        begin
            while (sent_bytes < 750)
            begin
                if ($urandom_range(0, 9) == 0)
                    sender_burst = ~sender_burst;
                r = $urandom_range(0, 99);
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
                h = $urandom_range(1, 4);
                if (r < 80)
                begin
                    img_type = $urandom_range(0, 1) ? TypeRle : TypeRaw;
                    depth = $urandom_range(0, 1) ? Depth32 : Depth24;
                    wide = (depth == Depth32);
                    total = w * h;
                    stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total - 1) : total;
                    send_header(8'h00, 8'h00, img_type, w[15:0], h[15:0], depth);
                    sent = 0;
                    while (sent < stop_at)
                    begin
                        if (img_type == TypeRle)
                        begin
                            count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                                 : $urandom_range(0, 5);
                            run = $urandom_range(0, 1);
                            send_byte({run, count[6:0]}, 1'b0);
                            n = (count + 1 < total - sent) ? count + 1 : total - sent;
                            if (run)
                                send_pixel(wide, $urandom);
                            else
                                repeat (n) send_pixel(wide, $urandom);
                            sent += n;
                        end
                        else
                        begin
                            send_pixel(wide, $urandom);
                            sent++;
                        end
                    end
                end
                else if (r < 92)
                begin
                    case ($urandom_range(0, 3))
                        0: send_header(8'($urandom_range(1, 255)), 8'h00, TypeRaw, w[15:0],
                                       h[15:0], Depth24);
                        1: send_header(8'h00, 8'($urandom_range(1, 255)), TypeRle, w[15:0],
                                       h[15:0], Depth32);
                        2: send_header(8'h00, 8'h00, 8'($urandom), w[15:0], h[15:0], Depth24);
                        default: send_header(8'h00, 8'h00, TypeRle, w[15:0], h[15:0],
                                             8'($urandom));
                    endcase
                end
                else
                begin
                    repeat ($urandom_range(1, 4))
                        send_byte(8'($urandom), $urandom_range(0, 7) == 0);
                end
                if ($urandom_range(0, 29) == 0)
                    wait_drained();
            end
        end
    endtask

    initial
    begin
        int on_len;
        int off_len;
        forever
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                on_len = $urandom_range(30, 80);
                off_len = 0;
            end
            else
            begin
                on_len = $urandom_range(1, 4);
                off_len = idle_len();
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            repeat (on_len - 1) @(negedge clk);
            if (off_len > 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (off_len - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        pixel_word_t got;
        pixel_word_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                   m_axis_tdata[31:24], m_axis_tdata[39:32], m_axis_tlast, m_axis_tuser};
            if (pending_words.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected word r=%h g=%h b=%h a=%h n=%0d last=%b status=%0d",
                         $time, got.red, got.green, got.blue, got.alpha, got.count,
                         got.last, got.status);
            end
            else
            begin
                want = pending_words.pop_front();
                words_checked++;
                if (got !== want)
                begin
                    mismatches++;
                    $display("%0t: expected r=%h g=%h b=%h a=%h n=%0d last=%b status=%0d",
                             $time, want.red, want.green, want.blue, want.alpha, want.count,
                             want.last, want.status);
                    $display("%0t:   actual r=%h g=%h b=%h a=%h n=%0d last=%b status=%0d",
                             $time, got.red, got.green, got.blue, got.alpha, got.count,
                             got.last, got.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("%0t: timeout with %0d words outstanding", $time, pending_words.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        test_bytes_before_start();
        test_bad_headers();
        test_empty_image();
        test_raw_pixels();
        test_rle_packets();
        test_restart();
        test_random_files();
        wait_drained();
        repeat (10) @(posedge clk);
        $display("Covered %0d files, %0d decoded bytes and %0d checked words,", files_started,
                 decoded_bytes, words_checked);
        $display("including header errors, empty images, clipped packets and restarts.");
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
